// ===== hdl/timestamp_lower_bound_search_unit_assert.svh =====
// assertion macros for the timestamp lower-bound search unit
// no dependencies; included by files that carry concurrent assertions
`ifndef TIMESTAMP_LOWER_BOUND_SEARCH_UNIT_ASSERT_SVH
`define TIMESTAMP_LOWER_BOUND_SEARCH_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TLBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TLBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TLBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TLBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/tlbs_pkg.sv =====
// shared types, constants and codes of the timestamp lower-bound search unit
// no dependencies
package tlbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int TIME_W      = 32;
    localparam int IDX_W       = 10;
    localparam int STAT_W      = 2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } tlbs_state_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  found_index;
    } tlbs_rsp_t;

    typedef struct packed {
        logic             we;
        logic [ADDR_W-1:0] waddr;
        logic [TIME_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } tlbs_ram_cmd_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } tlbs_stat_t;

endpackage

// ===== hdl/tlbs_req_if.sv =====
// request channel: append or query with a signed timestamp
// depends on tlbs_pkg
interface tlbs_req_if;
    import tlbs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic signed [TIME_W-1:0] time_value;

    modport source (output valid, output req_type, output time_value, input ready);
    modport sink   (input valid, input req_type, input time_value, output ready);
endinterface

// ===== hdl/tlbs_rsp_if.sv =====
// response channel: status and found index
// depends on tlbs_pkg
interface tlbs_rsp_if;
    import tlbs_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  found_index;

    modport source (output valid, output status, output found_index, input ready);
    modport sink   (input valid, input status, input found_index, output ready);
endinterface

// ===== hdl/tlbs_ram.sv =====
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
module tlbs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hdl/tlbs_search.sv =====
// request sequencer: appends, and binary search over the sample ram
// depends on tlbs_pkg and tlbs_req_if
module tlbs_search (
    input  logic                         clk,
    input  logic                         rst_n,
    tlbs_req_if.sink                     req,
    input  logic                         rsp_ok,
    output logic                         done,
    output tlbs_pkg::tlbs_rsp_t          result,
    output tlbs_pkg::tlbs_ram_cmd_t      ram_cmd,
    input  logic [tlbs_pkg::TIME_W-1:0]  ram_rdata,
    output tlbs_pkg::tlbs_stat_t         stat
);
    import tlbs_pkg::*;

    tlbs_state_t              state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [TIME_W-1:0] last_reg, last_next;
    logic signed [TIME_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [CNT_W-1:0]         mid_reg, mid_next;
    tlbs_rsp_t                res_reg, res_next;

    logic                     accept;
    logic                     less;
    logic signed [TIME_W-1:0] app_value;
    logic [CNT_W-1:0]         lo_step, hi_step, pick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        key_reg  <= key_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        res_reg  <= res_next;
    end

    assign req.ready = (state_reg == S_IDLE) && rsp_ok;
    assign accept    = req.valid && req.ready;

    // out-of-order appends are clamped to the last stored time
    assign app_value = ((count_reg != '0) && (req.time_value < last_reg)) ?
                       last_reg : req.time_value;

    // one halving step on the word read last cycle
    assign less    = $signed(ram_rdata) < key_reg;
    assign lo_step = less ? (mid_reg + CNT_W'(1)) : lo_reg;
    assign hi_step = less ? hi_reg : mid_reg;
    assign pick    = (lo_step == count_reg) ? (count_reg - CNT_W'(1)) : lo_step;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        last_next     = last_reg;
        key_next      = key_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        res_next      = res_reg;
        done          = 1'b0;
        result        = res_reg;
        ram_cmd.we    = 1'b0;
        ram_cmd.waddr = count_reg[ADDR_W-1:0];
        ram_cmd.wdata = app_value;
        ram_cmd.raddr = mid_reg[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == REQ_APPEND)
                    begin
                        done               = 1'b1;
                        result.found_index = '0;
                        if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            result.status = STAT_FULL;
                        end
                        else
                        begin
                            result.status = STAT_OK;
                            ram_cmd.we    = 1'b1;
                            count_next    = count_reg + CNT_W'(1);
                            last_next     = app_value;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done               = 1'b1;
                        result.status      = STAT_EMPTY;
                        result.found_index = '0;
                    end
                    else
                    begin
                        key_next      = req.time_value;
                        lo_next       = '0;
                        hi_next       = count_reg;
                        mid_next      = count_reg >> 1;
                        ram_cmd.raddr = mid_next[ADDR_W-1:0];
                        state_next    = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                lo_next = lo_step;
                hi_next = hi_step;
                if (lo_step < hi_step)
                begin
                    mid_next      = lo_step + ((hi_step - lo_step) >> 1);
                    ram_cmd.raddr = mid_next[ADDR_W-1:0];
                end
                else
                begin
                    res_next.status      = STAT_OK;
                    res_next.found_index = IDX_W'(pick);
                    state_next           = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (rsp_ok)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign stat.busy  = (state_reg != S_IDLE);
    assign stat.count = count_reg;
endmodule

// ===== hdl/timestamp_lower_bound_search_unit.sv =====
// timestamp lower-bound search unit: appends sorted timestamps, answers lower-bound queries
// an append or an empty-table query loads the output register at its transfer edge, so
// its result is offered the next cycle; such requests follow one per cycle while rsp drains
// a query runs the binary search over the ram, then waits in S_FINISH until the output
// register can take its result; no request is taken until the sequencer is idle again
// reset clears the sample count and the sequencer; ram contents stay undefined, no clearing pass
`include "timestamp_lower_bound_search_unit_assert.svh"

module timestamp_lower_bound_search_unit (
    input  logic      clk,
    input  logic      rst_n,
    tlbs_req_if.sink  req,
    tlbs_rsp_if.source rsp
);
    import tlbs_pkg::*;

    // sequencer to ram and output stage
    tlbs_ram_cmd_t      ram_cmd;
    logic [TIME_W-1:0]  ram_rdata;
    tlbs_rsp_t          result;
    tlbs_stat_t         stat;
    logic               done;
    logic               rsp_ok;

    // output register, parts the response side from the sequencer
    logic               out_valid_reg, out_valid_next;
    tlbs_rsp_t          out_data_reg, out_data_next;

    tlbs_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_ok    (rsp_ok),
        .done      (done),
        .result    (result),
        .ram_cmd   (ram_cmd),
        .ram_rdata (ram_rdata),
        .stat      (stat)
    );

    // sample store; appends and searches never overlap, so no forwarding is needed
    tlbs_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (TIME_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_cmd.we),
        .waddr (ram_cmd.waddr),
        .wdata (ram_cmd.wdata),
        .raddr (ram_cmd.raddr),
        .rdata (ram_rdata)
    );

    // a new result may load when the register is empty or being drained this cycle
    assign rsp_ok = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_data_reg.status;
    assign rsp.found_index = out_data_reg.found_index;

    // a finished result never overwrites one that is still waiting
    `TLBS_ASSERT_IMP(a_no_overwrite, clk, rst_n, done, rsp_ok, "result overwrote pending transfer")
    // a dropped append only happens on a full table
    `TLBS_ASSERT_IMP(a_full_only_at_depth, clk, rst_n, done && (result.status == STAT_FULL),
        stat.count == CNT_W'(TABLE_DEPTH), "full status with free entries")
    // a query on a non-empty table starts a search
    `TLBS_ASSERT_NXT(a_query_searches, clk, rst_n,
        req.valid && req.ready && (req.req_type == REQ_QUERY) && (stat.count != '0),
        stat.busy && !req.ready, "query did not enter search")
endmodule
